@@ design/bdsd_pkg.sv @@
`timescale 1ns / 1ps
package bdsd_pkg;

  localparam int PORT_WORD_W = 16;
  localparam int LIMIT_W     = 10;
  localparam int PIN_W       = 4;
  localparam int GCR_W       = 32;
  localparam int CFG_DATA_W  = 10;
  localparam int CFG_IDX_W   = 1;

  // Pins at or above this position read as low
  localparam int PORT_WIDTH = 16;

  localparam int OVERSAMPLE_DEF    = 5;
  localparam int RESPONSE_BITS_DEF = 21;

  localparam logic [LIMIT_W-1:0] SEARCH_LIMIT_RST = 10'd60;
  localparam logic [PIN_W-1:0]   PIN_SELECT_RST   = 4'd0;

  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIN_SELECT   = 1'd1;

  typedef struct packed {
    logic [PORT_WORD_W-1:0] port_word;
    logic                   capture_start;
  } sample_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] search_limit;
    logic [PIN_W-1:0]   pin_select;
  } cfg_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_SEARCH = 3'b010,
    PH_DECODE = 3'b100
  } phase_t;

endpackage

@@ design/bdsd_in_stage.sv @@
`timescale 1ns / 1ps
module bdsd_in_stage
  import bdsd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  sample_t in_sample,
  input  logic    advance,
  output logic    s1_valid,
  output sample_t s1_sample
);

  // take a new transaction whenever the held one moves on this cycle
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_sample <= in_sample;
    end
  end

endmodule

@@ design/bdsd_decode.sv @@
`timescale 1ns / 1ps
module bdsd_decode
  import bdsd_pkg::*;
#(
  parameter int OVERSAMPLE    = OVERSAMPLE_DEF,
  parameter int RESPONSE_BITS = RESPONSE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             s1_valid,
  input  sample_t          s1_sample,
  output logic             advance,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [GCR_W-1:0] gcr_word,
  output logic             no_response
);

  localparam int SPAN = RESPONSE_BITS * OVERSAMPLE;
  localparam int DC_W = $clog2(SPAN);
  localparam int SC_W = (DC_W > LIMIT_W) ? DC_W : LIMIT_W;
  localparam int Q_W  = $clog2(RESPONSE_BITS + 1);
  localparam int R_W  = $clog2(OVERSAMPLE);
  localparam int BD_W = $clog2(SPAN + 1);
  localparam logic [GCR_W-1:0] ONES_RB = GCR_W'((64'd1 << RESPONSE_BITS) - 64'd1);

  phase_t             phase, phase_next;
  logic [SC_W-1:0]    sample_count, sample_count_next;
  logic [Q_W-1:0]     run_quot, run_quot_next;
  logic [R_W-1:0]     run_rem, run_rem_next;
  logic               last_level, last_level_next;
  logic [BD_W-1:0]    bits_decoded, bits_decoded_next;
  logic [GCR_W-1:0]   shift_word, shift_word_next;
  logic               emit;
  logic               emit_none;
  logic               level;

  assign advance = !out_valid || out_ready;
  assign level   = (int'(cfg.pin_select) < PORT_WIDTH) ?
                   s1_sample.port_word[cfg.pin_select] : 1'b0;

  always_comb begin
    logic [SC_W-1:0] sc_inc;
    logic [Q_W-1:0]  len;
    logic [Q_W-1:0]  len_c;
    logic [Q_W-1:0]  rest;

    phase_next        = phase;
    sample_count_next = sample_count;
    run_quot_next     = run_quot;
    run_rem_next      = run_rem;
    last_level_next   = last_level;
    bits_decoded_next = bits_decoded;
    shift_word_next   = shift_word;
    emit              = 1'b0;
    emit_none         = 1'b0;
    sc_inc            = '0;
    len               = '0;
    len_c             = '0;
    rest              = '0;

    // restart: drop any running capture
    if (s1_sample.capture_start) begin
      phase_next        = PH_SEARCH;
      sample_count_next = '0;
      run_quot_next     = '0;
      run_rem_next      = '0;
      last_level_next   = 1'b1;
      bits_decoded_next = '0;
      shift_word_next   = '0;
    end

    case (phase_next)
      PH_SEARCH: begin
        if (sample_count_next < SC_W'(cfg.search_limit) && !level) begin
          phase_next        = PH_DECODE;
          sample_count_next = '0;
          run_quot_next     = '0;
          run_rem_next      = '0;
          last_level_next   = 1'b0;
          bits_decoded_next = '0;
          shift_word_next   = '0;
        end else begin
          sc_inc            = sample_count_next + SC_W'(1);
          sample_count_next = sc_inc;
          if (sc_inc >= SC_W'(cfg.search_limit)) begin
            emit       = 1'b1;
            emit_none  = 1'b1;
            phase_next = PH_IDLE;
          end
        end
      end
      PH_DECODE: begin
        // run length kept as quotient and remainder of OVERSAMPLE
        if (run_rem_next == R_W'(OVERSAMPLE - 1)) begin
          run_rem_next  = '0;
          run_quot_next = run_quot_next + Q_W'(1);
        end else begin
          run_rem_next = run_rem_next + R_W'(1);
        end
        if (level != last_level_next) begin
          len               = (run_quot_next == '0) ? Q_W'(1) : run_quot_next;
          len_c             = (len > Q_W'(RESPONSE_BITS)) ? Q_W'(RESPONSE_BITS) : len;
          bits_decoded_next = bits_decoded_next + BD_W'(len);
          shift_word_next   = shift_word_next << len;
          if (last_level_next) begin
            shift_word_next = shift_word_next | ~({GCR_W{1'b1}} << len_c);
          end
          last_level_next = level;
          run_quot_next   = '0;
          run_rem_next    = '0;
        end
        sample_count_next = sample_count_next + SC_W'(1);
        if (sample_count_next >= SC_W'(SPAN - 1)) begin
          rest = (bits_decoded_next >= BD_W'(RESPONSE_BITS)) ? '0 :
                 Q_W'(RESPONSE_BITS) - Q_W'(bits_decoded_next);
          shift_word_next = (shift_word_next << rest) | (ONES_RB >> bits_decoded_next);
          emit            = 1'b1;
          phase_next      = PH_IDLE;
        end
      end
      default: begin
        // idle: ignore samples until the next start
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      sample_count <= '0;
      run_quot     <= '0;
      run_rem      <= '0;
      last_level   <= 1'b1;
      bits_decoded <= '0;
      shift_word   <= '0;
      out_valid    <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid && emit;
      if (s1_valid) begin
        phase        <= phase_next;
        sample_count <= sample_count_next;
        run_quot     <= run_quot_next;
        run_rem      <= run_rem_next;
        last_level   <= last_level_next;
        bits_decoded <= bits_decoded_next;
        shift_word   <= shift_word_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid && emit) begin
      gcr_word    <= emit_none ? {GCR_W{1'b1}} : shift_word_next;
      no_response <= emit_none;
    end
  end

`ifndef SYNTHESIS
  a_none_all_ones: assert property (@(posedge clk) disable iff (rst)
    out_valid && no_response |-> gcr_word == {GCR_W{1'b1}})
    else $error("no_response result without all-ones word");

  a_idle_silent: assert property (@(posedge clk) disable iff (rst)
    advance && s1_valid && phase == PH_IDLE && !s1_sample.capture_start |=> !out_valid)
    else $error("result produced from idle without a start");

  a_span_bound: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DECODE |-> sample_count < SC_W'(SPAN - 1))
    else $error("decode ran past the response span");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    !advance |=> out_valid && $stable(shift_word) && $stable(phase))
    else $error("decoder state moved while the result was stalled");
`endif

endmodule

@@ design/bdshot_oversampled_response_decoder_top.sv @@
`timescale 1ns / 1ps
// Channel   Signals                                   Direction
// input     in_valid/in_ready, port_word, capture_start   in
// output    out_valid/out_ready, gcr_word, no_response    out
// config    cfg_write, cfg_index, cfg_data             in (write only)
//
// One sample per cycle is accepted while the result is not stalled; the decode is
// a single pass between the input register and the result register, so a result
// is registered from the input register that holds the sample that completes it.
// Reset (rst, synchronous) returns to idle and loads search_limit 60, pin 0.
// A stalled result holds the decoder; one more sample can still be taken
// into the input register meanwhile.
module bdshot_oversampled_response_decoder_top
  import bdsd_pkg::*;
#(
  parameter int OVERSAMPLE    = OVERSAMPLE_DEF,
  parameter int RESPONSE_BITS = RESPONSE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [PORT_WORD_W-1:0] port_word,
  input  logic                   capture_start,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [GCR_W-1:0]       gcr_word,
  output logic                   no_response
);

  cfg_t    cfg;
  sample_t in_sample;
  sample_t s1_sample;
  logic    s1_valid;
  logic    advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.search_limit <= SEARCH_LIMIT_RST;
      cfg.pin_select   <= PIN_SELECT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SEARCH_LIMIT: cfg.search_limit <= cfg_data[LIMIT_W-1:0];
        CFG_PIN_SELECT:   cfg.pin_select   <= cfg_data[PIN_W-1:0];
        default: begin
          // unknown index: drop the write
        end
      endcase
    end
  end

  assign in_sample.port_word     = port_word;
  assign in_sample.capture_start = capture_start;

  bdsd_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sample (in_sample),
    .advance   (advance),
    .s1_valid  (s1_valid),
    .s1_sample (s1_sample)
  );

  bdsd_decode #(
    .OVERSAMPLE    (OVERSAMPLE),
    .RESPONSE_BITS (RESPONSE_BITS)
  ) u_decode (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .s1_valid    (s1_valid),
    .s1_sample   (s1_sample),
    .advance     (advance),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .gcr_word    (gcr_word),
    .no_response (no_response)
  );

`ifndef SYNTHESIS
  a_backpressure_source: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready && s1_valid)
    else $error("input stalled without a stalled result");
`endif

endmodule

@@ tb/sv/bdsd_response_checker.sv @@
`timescale 1ns / 1ps
module bdsd_response_checker
  import bdsd_pkg::*;
#(
  parameter int OVERSAMPLE    = OVERSAMPLE_DEF,
  parameter int RESPONSE_BITS = RESPONSE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [PORT_WORD_W-1:0] port_word,
  input  logic                   capture_start,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [GCR_W-1:0]       gcr_word,
  input  logic                   no_response,
  output int                     mismatches,
  output int                     awaited,
  output int                     responses
);

  localparam int unsigned SPAN = OVERSAMPLE * RESPONSE_BITS;
  localparam logic [GCR_W-1:0] ONES_RB = (32'd1 << RESPONSE_BITS) - 32'd1;

  typedef struct packed {
    logic [GCR_W-1:0] gcr;
    logic             none;
  } resp_t;

  resp_t resp_q[$];
  resp_t want;

  logic [LIMIT_W-1:0] limit;
  logic [PIN_W-1:0]   pin_sel;

  phase_t           phase;
  logic [10:0]      samp_cnt;
  logic [10:0]      run_len;
  logic             last_lvl;
  logic [10:0]      bits_done;
  logic [GCR_W-1:0] shreg;

  int err_cnt = 0;
  int seen_cnt = 0;

  task automatic post_result(input logic [GCR_W-1:0] gcr, input logic none);
    resp_t r;
    r.gcr = gcr;
    r.none = none;
    resp_q.push_back(r);
    phase = PH_IDLE;
  endtask

  task automatic clear_capture(input logic lvl);
    samp_cnt = '0;
    run_len = '0;
    last_lvl = lvl;
    bits_done = '0;
    shreg = '0;
  endtask

  // One accepted sample through the line decoder.
  task automatic take_sample(input logic [PORT_WORD_W-1:0] pw, input logic st);
    logic        lvl;
    int unsigned d;
    int unsigned run;
    int unsigned len;
    int unsigned sh;
    int unsigned rest;
    lvl = (pin_sel < PORT_WIDTH) ? pw[pin_sel] : 1'b0;
    if (st) begin
      phase = PH_SEARCH;
      clear_capture(1'b1);
    end
    case (phase)
      PH_SEARCH: begin
        if (samp_cnt < limit && !lvl) begin
          phase = PH_DECODE;
          clear_capture(1'b0);
        end else begin
          samp_cnt = samp_cnt + 11'd1;
          if (samp_cnt >= limit) post_result('1, 1'b1);
        end
      end
      PH_DECODE: begin
        d = samp_cnt + 1;
        run = run_len + 1;
        if (lvl != last_lvl) begin
          len = run / OVERSAMPLE;
          if (len < 1) len = 1;
          bits_done = 11'(bits_done + len);
          shreg = shreg << len;
          // a finished high run inserts ones, capped at the response width
          if (last_lvl) begin
            sh = (len >= RESPONSE_BITS) ? 0 : RESPONSE_BITS - len;
            shreg = shreg | (ONES_RB >> sh);
          end
          last_lvl = lvl;
          run = 0;
        end
        samp_cnt = 11'(d);
        run_len = 11'(run);
        if (d >= SPAN - 1) begin
          rest = (bits_done >= RESPONSE_BITS) ? 0 : RESPONSE_BITS - bits_done;
          shreg = shreg << rest;
          shreg = shreg | (ONES_RB >> bits_done);
          post_result(shreg, 1'b0);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      limit = SEARCH_LIMIT_RST;
      pin_sel = PIN_SELECT_RST;
      phase = PH_IDLE;
      clear_capture(1'b1);
      resp_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_SEARCH_LIMIT: limit = cfg_data[LIMIT_W-1:0];
          CFG_PIN_SELECT:   pin_sel = cfg_data[PIN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) take_sample(port_word, capture_start);
      if (out_valid && out_ready) begin
        seen_cnt++;
        if (resp_q.size() == 0) begin
          $error("unexpected transaction: gcr_word %h no_response %b", gcr_word, no_response);
          err_cnt++;
        end else begin
          want = resp_q.pop_front();
          if (gcr_word !== want.gcr) begin
            $error("gcr_word: expected %h, actual %h", want.gcr, gcr_word);
            err_cnt++;
          end
          if (no_response !== want.none) begin
            $error("no_response: expected %b, actual %b", want.none, no_response);
            err_cnt++;
          end
        end
      end
    end
    mismatches <= err_cnt;
    awaited <= resp_q.size();
    responses <= seen_cnt;
  end

endmodule

@@ tb/sv/tb_bdshot_oversampled_response_decoder_top.sv @@
`timescale 1ns / 1ps
module tb_bdshot_oversampled_response_decoder_top;
  import bdsd_pkg::*;

  localparam int OVERSAMPLE    = OVERSAMPLE_DEF;
  localparam int RESPONSE_BITS = RESPONSE_BITS_DEF;
  localparam int unsigned SPAN = OVERSAMPLE * RESPONSE_BITS;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = CFG_SEARCH_LIMIT;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [PORT_WORD_W-1:0] port_word = '0;
  logic                   capture_start = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [GCR_W-1:0]       gcr_word;
  logic                   no_response;

  int mismatches;
  int awaited;
  int responses;

  int          send_gap_pct = 12;
  int          recv_stall_pct = 69;
  int unsigned items_sent = 0;

  logic [LIMIT_W-1:0] cur_limit = SEARCH_LIMIT_RST;
  logic [PIN_W-1:0]   cur_pin = PIN_SELECT_RST;

  bit line_q[$];

  bdshot_oversampled_response_decoder_top u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .port_word    (port_word),
    .capture_start(capture_start),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .gcr_word     (gcr_word),
    .no_response  (no_response)
  );

  bdsd_response_checker #(
    .OVERSAMPLE   (OVERSAMPLE),
    .RESPONSE_BITS(RESPONSE_BITS)
  ) u_chk (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .port_word    (port_word),
    .capture_start(capture_start),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .gcr_word     (gcr_word),
    .no_response  (no_response),
    .mismatches   (mismatches),
    .awaited      (awaited),
    .responses    (responses)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    out_ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_sample(input logic [PORT_WORD_W-1:0] pw, input logic st);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    port_word <= pw;
    capture_start <= st;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Random port word with the watched pin forced to the line level.
  function automatic logic [PORT_WORD_W-1:0] line_word(input logic lvl);
    logic [PORT_WORD_W-1:0] w;
    w = PORT_WORD_W'($urandom);
    w[cur_pin] = lvl;
    return w;
  endfunction

  // Drain all results and let the pipeline empty before touching registers.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic apply_setting();
    cfg_write <= 1'b1;
    cfg_index <= CFG_SEARCH_LIMIT;
    cfg_data <= cur_limit;
    @(posedge clk);
    cfg_index <= CFG_PIN_SELECT;
    cfg_data <= CFG_DATA_W'(cur_pin);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic run_capture();
    int unsigned kind;
    int unsigned lead;
    int unsigned width;
    int unsigned n;
    int unsigned pad;
    int unsigned jit;
    logic [RESPONSE_BITS-1:0] bits;
    line_q.delete();
    kind = $urandom_range(99);
    // long silent captures only now and then at large search windows
    if (kind >= 60 && kind < 70 && cur_limit > 100 && $urandom_range(19) != 0) kind = 0;
    if (kind < 60 || (kind >= 78 && kind < 88)) begin
      if (cur_limit <= 1) lead = 0;
      else if (cur_limit <= 200 && $urandom_range(7) == 0) lead = cur_limit - 1;
      else lead = $urandom_range(0, (cur_limit - 1 < 24) ? cur_limit - 1 : 24);
      repeat (lead) line_q.push_back(1'b1);
      bits = RESPONSE_BITS'($urandom);
      bits[RESPONSE_BITS-1] = 1'b0;
      jit = $urandom_range(2);
      n = 0;
      for (int b = RESPONSE_BITS - 1; b >= 0; b--) begin
        case (jit)
          0:       width = OVERSAMPLE;
          1:       width = OVERSAMPLE + $urandom_range(2) - 1;
          default: width = $urandom_range(1, 3 * OVERSAMPLE);
        endcase
        repeat (width) line_q.push_back(bits[b]);
        n += width;
      end
      pad = $urandom_range(3);
      while (n < SPAN + pad) begin
        line_q.push_back(1'b1);
        n++;
      end
      // broken frame: cut short, the next start drops it
      if (kind >= 78) begin
        n = $urandom_range(1, line_q.size() - 1);
        while (line_q.size() > n) void'(line_q.pop_back());
      end
    end else if (kind < 70) begin
      repeat (cur_limit + $urandom_range(1, 3)) line_q.push_back(1'b1);
    end else if (kind < 78) begin
      // toggle every sample: far more bits than the word holds
      for (int i = 0; i < SPAN + 2; i++) line_q.push_back(1'(i % 2));
    end else begin
      repeat ($urandom_range(1, 40)) send_sample(PORT_WORD_W'($urandom), $urandom_range(15) == 0);
    end
    foreach (line_q[i]) send_sample(line_word(line_q[i]), i == 0);
  endtask

  initial begin
    int base;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // idle samples, restarts during a capture, field extremes
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'hFFFE, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0000, 1'b1);
    send_sample(16'hAAAA, 1'b0);
    send_sample(16'h5555, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b0);

    for (int seg = 0; seg < 6; seg++) begin
      settle();
      case (seg)
        0: begin cur_limit = SEARCH_LIMIT_RST; cur_pin = PIN_SELECT_RST; end
        1: begin cur_limit = 10'd1; cur_pin = 4'd15; end
        2: begin cur_limit = 10'd1023; cur_pin = 4'd7; end
        3: begin cur_limit = 10'd0; cur_pin = 4'd3; end
        4: begin
          cur_limit = LIMIT_W'($urandom_range(2, 120));
          cur_pin = PIN_W'($urandom);
        end
        default: begin
          cur_limit = LIMIT_W'($urandom_range(1, 1023));
          cur_pin = PIN_W'($urandom);
        end
      endcase
      if (seg < 2) begin
        send_gap_pct = 12;
        recv_stall_pct = 69;
      end else if (seg < 4) begin
        send_gap_pct = 69;
        recv_stall_pct = 12;
      end else begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      apply_setting();
      base = responses;
      while (responses - base < 9 || items_sent < 240 * (seg + 1)) run_capture();
    end

    settle();
    if (mismatches == 0 && awaited == 0) begin
      $display("bdshot_oversampled_response_decoder_top test passed");
    end else begin
      $display("bdshot_oversampled_response_decoder_top test failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("bdshot_oversampled_response_decoder_top test failed");
    $finish;
  end

endmodule
